>>> hw/rtl/assert_macros.svh
// Assertion macros for the RTL files; the top-level builder includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SAB_ASSERT_IMP(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`define SAB_ASSERT_NXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define SAB_ASSERT_IMP(label, clk, rst_n, a, b)
`define SAB_ASSERT_NXT(label, clk, rst_n, a, b)
`endif
`endif

>>> hw/rtl/sab_pkg.sv
// ----------------------------------------------------------------------------
// Suffix automaton builder package
// Word types, mode codes, controller states and datapath operations.
// ----------------------------------------------------------------------------
package sab_pkg;

    localparam logic [1:0] MODE_RESTART = 2'd0;
    localparam logic [1:0] MODE_APPEND  = 2'd1;
    localparam logic [1:0] MODE_QUERY   = 2'd2;

    typedef struct packed {
        logic [1:0]  mode;
        logic [4:0]  symbol;
        logic [11:0] query_state;
    } t_in;

    typedef struct packed {
        logic [11:0] new_state;
        logic [11:0] state_total;
        logic        cloned;
        logic [10:0] state_length;
        logic [11:0] suffix_link;
        logic [11:0] transition;
        logic        overflow;
    } t_out;

    typedef enum logic [4:0] {
        OP_NONE, OP_CLR_INIT, OP_CLR_ROW, OP_APP_INIT, OP_ZERO_ROW, OP_RD_PC,
        OP_SET_CUR, OP_STEP_P, OP_LINK_ROOT, OP_TAKE_Q, OP_TAKE_QL, OP_TAKE_PL,
        OP_LINK_Q, OP_CL_INIT, OP_CP_RD, OP_CP_WR, OP_RD_LQ, OP_WR_LCL,
        OP_WR_LCUR, OP_WR_LQ, OP_SET_CL, OP_QUERY, OP_OVF, OP_EMIT
    } t_op;

    typedef enum logic [4:0] {
        S_RCLR, S_IDLE, S_DISP, S_CINI, S_CLR, S_OVF, S_AINIT, S_AZERO, S_ARD,
        S_ACHK, S_ASET, S_ASTEP, S_AROOT, S_AQ, S_AQL, S_APL, S_ALQ, S_CINIT,
        S_CRD, S_CWR, S_CLQ, S_CWL, S_CWC, S_CWQ, S_RRD, S_RCHK, S_RSET,
        S_RSTEP, S_QRD, S_DONE
    } t_state;

    typedef struct packed {
        logic latch;
        t_op  op;
    } t_cmd;

    typedef struct packed {
        logic [1:0] mode;
        logic       sym_ok;
        logic       room;
        logic       k_last;
        logic       next_zero;
        logic       next_is_q;
        logic       len_match;
        logic       p_zero;
    } t_sts;

endpackage

>>> hw/rtl/sab_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sab_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 2050
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> hw/rtl/sab_ctrl.sv
// ----------------------------------------------------------------------------
// Suffix automaton controller
// Sequences restart, append, clone and query operations of the datapath.
// ----------------------------------------------------------------------------
module sab_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  sab_pkg::t_sts i_sts,
    output sab_pkg::t_cmd o_cmd,
    output logic          o_busy
);
    sab_pkg::t_state r_state;
    sab_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sab_pkg::S_RCLR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sab_pkg::S_RCLR: if (i_sts.k_last) n_state = sab_pkg::S_IDLE;
            sab_pkg::S_IDLE: if (i_start) n_state = sab_pkg::S_DISP;
            sab_pkg::S_DISP: begin
                priority if (i_sts.mode == sab_pkg::MODE_RESTART) begin
                    n_state = sab_pkg::S_CINI;
                end else if (i_sts.mode == sab_pkg::MODE_APPEND) begin
                    priority if (!i_sts.sym_ok) n_state = sab_pkg::S_DONE;
                    else if (!i_sts.room) n_state = sab_pkg::S_OVF;
                    else n_state = sab_pkg::S_AINIT;
                end else if (i_sts.mode == sab_pkg::MODE_QUERY) begin
                    n_state = sab_pkg::S_QRD;
                end else begin
                    n_state = sab_pkg::S_DONE;
                end
            end
            sab_pkg::S_CINI:  n_state = sab_pkg::S_CLR;
            sab_pkg::S_CLR:   if (i_sts.k_last) n_state = sab_pkg::S_DONE;
            sab_pkg::S_OVF:   n_state = sab_pkg::S_DONE;
            sab_pkg::S_AINIT: n_state = sab_pkg::S_AZERO;
            sab_pkg::S_AZERO: if (i_sts.k_last) n_state = sab_pkg::S_ARD;
            sab_pkg::S_ARD:   n_state = sab_pkg::S_ACHK;
            sab_pkg::S_ACHK:  n_state = i_sts.next_zero ? sab_pkg::S_ASET : sab_pkg::S_AQ;
            sab_pkg::S_ASET:  n_state = sab_pkg::S_ASTEP;
            sab_pkg::S_ASTEP: n_state = i_sts.p_zero ? sab_pkg::S_AROOT : sab_pkg::S_ARD;
            sab_pkg::S_AROOT: n_state = sab_pkg::S_DONE;
            sab_pkg::S_AQ:    n_state = sab_pkg::S_AQL;
            sab_pkg::S_AQL:   n_state = sab_pkg::S_APL;
            sab_pkg::S_APL:   n_state = i_sts.len_match ? sab_pkg::S_ALQ : sab_pkg::S_CINIT;
            sab_pkg::S_ALQ:   n_state = sab_pkg::S_DONE;
            sab_pkg::S_CINIT: n_state = sab_pkg::S_CRD;
            sab_pkg::S_CRD:   n_state = sab_pkg::S_CWR;
            sab_pkg::S_CWR:   n_state = i_sts.k_last ? sab_pkg::S_CLQ : sab_pkg::S_CRD;
            sab_pkg::S_CLQ:   n_state = sab_pkg::S_CWL;
            sab_pkg::S_CWL:   n_state = sab_pkg::S_CWC;
            sab_pkg::S_CWC:   n_state = sab_pkg::S_CWQ;
            sab_pkg::S_CWQ:   n_state = sab_pkg::S_RRD;
            sab_pkg::S_RRD:   n_state = sab_pkg::S_RCHK;
            sab_pkg::S_RCHK:  n_state = i_sts.next_is_q ? sab_pkg::S_RSET : sab_pkg::S_DONE;
            sab_pkg::S_RSET:  n_state = sab_pkg::S_RSTEP;
            sab_pkg::S_RSTEP: n_state = i_sts.p_zero ? sab_pkg::S_DONE : sab_pkg::S_RRD;
            sab_pkg::S_QRD:   n_state = sab_pkg::S_DONE;
            sab_pkg::S_DONE:  n_state = sab_pkg::S_IDLE;
            default:          n_state = sab_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.latch = 1'b0;
        o_cmd.op    = sab_pkg::OP_NONE;
        unique case (r_state)
            sab_pkg::S_RCLR:  o_cmd.op = sab_pkg::OP_CLR_ROW;
            sab_pkg::S_IDLE:  o_cmd.latch = i_start;
            sab_pkg::S_CINI:  o_cmd.op = sab_pkg::OP_CLR_INIT;
            sab_pkg::S_CLR:   o_cmd.op = sab_pkg::OP_CLR_ROW;
            sab_pkg::S_OVF:   o_cmd.op = sab_pkg::OP_OVF;
            sab_pkg::S_AINIT: o_cmd.op = sab_pkg::OP_APP_INIT;
            sab_pkg::S_AZERO: o_cmd.op = sab_pkg::OP_ZERO_ROW;
            sab_pkg::S_ARD:   o_cmd.op = sab_pkg::OP_RD_PC;
            sab_pkg::S_ASET:  o_cmd.op = sab_pkg::OP_SET_CUR;
            sab_pkg::S_ASTEP: o_cmd.op = sab_pkg::OP_STEP_P;
            sab_pkg::S_AROOT: o_cmd.op = sab_pkg::OP_LINK_ROOT;
            sab_pkg::S_AQ:    o_cmd.op = sab_pkg::OP_TAKE_Q;
            sab_pkg::S_AQL:   o_cmd.op = sab_pkg::OP_TAKE_QL;
            sab_pkg::S_APL:   o_cmd.op = sab_pkg::OP_TAKE_PL;
            sab_pkg::S_ALQ:   o_cmd.op = sab_pkg::OP_LINK_Q;
            sab_pkg::S_CINIT: o_cmd.op = sab_pkg::OP_CL_INIT;
            sab_pkg::S_CRD:   o_cmd.op = sab_pkg::OP_CP_RD;
            sab_pkg::S_CWR:   o_cmd.op = sab_pkg::OP_CP_WR;
            sab_pkg::S_CLQ:   o_cmd.op = sab_pkg::OP_RD_LQ;
            sab_pkg::S_CWL:   o_cmd.op = sab_pkg::OP_WR_LCL;
            sab_pkg::S_CWC:   o_cmd.op = sab_pkg::OP_WR_LCUR;
            sab_pkg::S_CWQ:   o_cmd.op = sab_pkg::OP_WR_LQ;
            sab_pkg::S_RRD:   o_cmd.op = sab_pkg::OP_RD_PC;
            sab_pkg::S_RSET:  o_cmd.op = sab_pkg::OP_SET_CL;
            sab_pkg::S_RSTEP: o_cmd.op = sab_pkg::OP_STEP_P;
            sab_pkg::S_QRD:   o_cmd.op = sab_pkg::OP_QUERY;
            sab_pkg::S_DONE:  o_cmd.op = sab_pkg::OP_EMIT;
            default:          o_cmd.op = sab_pkg::OP_NONE;
        endcase
    end

    assign o_busy = (r_state != sab_pkg::S_IDLE);
endmodule

>>> hw/rtl/sab_dp.sv
// ----------------------------------------------------------------------------
// Suffix automaton datapath
// State registers and the transition, length and link memories.
// ----------------------------------------------------------------------------
module sab_dp #(
    parameter int MAX_LEN  = 1024,
    parameter int ALPHABET = 26
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  sab_pkg::t_cmd i_cmd,
    input  sab_pkg::t_in  i_item,
    output sab_pkg::t_sts o_sts,
    output sab_pkg::t_out o_result,
    output logic          o_strobe
);
    localparam int NSTATES = 2 * MAX_LEN + 2;
    localparam int SW = $clog2(NSTATES);
    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int KW = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
    localparam int ND = NSTATES * ALPHABET;
    localparam int AW = $clog2(ND);
    localparam int EW = (SW > 12) ? SW : 12;

    sab_pkg::t_in  r_item;
    sab_pkg::t_out r_result;
    logic          r_strobe;
    logic [SW-1:0] r_last, r_cnt, r_cur, r_p, r_q, r_cl;
    logic [LW-1:0] r_llen, r_qlen, r_plen;
    logic [KW-1:0] r_k, r_c;
    logic          r_cloned, r_ovf;

    logic          nx_we, nx_re, ln_we, ln_re, lk_we, lk_re;
    logic [AW-1:0] nx_wa, nx_ra;
    logic [SW-1:0] nx_wd, nx_rd, ln_wa, ln_ra, lk_wa, lk_ra, lk_wd, lk_rd;
    logic [LW-1:0] ln_wd, ln_rd;
    logic [LW-1:0] plen_now;
    logic          k_last, sym_ok, q_in, q_in2, is_query;

    function automatic logic [AW-1:0] f_addr(input logic [SW-1:0] row,
                                             input logic [KW-1:0] col);
        return AW'(row) * AW'(ALPHABET) + AW'(col);
    endfunction

    assign k_last   = (r_k == KW'(ALPHABET - 1));
    assign sym_ok   = (32'(r_item.symbol) < ALPHABET);
    assign plen_now = (r_p == SW'(1)) ? '0 : ln_rd;
    assign q_in     = (EW'(r_item.query_state) >= EW'(1))
                      && (EW'(r_item.query_state) <= EW'(r_cnt));
    assign q_in2    = q_in && (r_item.query_state != 12'd1);
    assign is_query = (r_item.mode == sab_pkg::MODE_QUERY);

    always_comb begin
        nx_we = 1'b0; nx_wa = '0; nx_wd = '0; nx_re = 1'b0; nx_ra = '0;
        ln_we = 1'b0; ln_wa = '0; ln_wd = '0; ln_re = 1'b0; ln_ra = '0;
        lk_we = 1'b0; lk_wa = '0; lk_wd = '0; lk_re = 1'b0; lk_ra = '0;
        unique case (i_cmd.op)
            sab_pkg::OP_CLR_ROW: begin
                nx_we = 1'b1; nx_wa = f_addr(SW'(1), r_k);
            end
            sab_pkg::OP_APP_INIT: begin
                ln_we = 1'b1; ln_wa = r_cnt + SW'(1); ln_wd = r_llen + LW'(1);
            end
            sab_pkg::OP_ZERO_ROW: begin
                nx_we = 1'b1; nx_wa = f_addr(r_cur, r_k);
            end
            sab_pkg::OP_RD_PC: begin
                nx_re = 1'b1; nx_ra = f_addr(r_p, r_c);
            end
            sab_pkg::OP_SET_CUR: begin
                nx_we = 1'b1; nx_wa = f_addr(r_p, r_c); nx_wd = r_cur;
                lk_re = 1'b1; lk_ra = r_p;
            end
            sab_pkg::OP_LINK_ROOT: begin
                lk_we = 1'b1; lk_wa = r_cur; lk_wd = SW'(1);
            end
            sab_pkg::OP_TAKE_Q: begin
                ln_re = 1'b1; ln_ra = nx_rd;
            end
            sab_pkg::OP_TAKE_QL: begin
                ln_re = 1'b1; ln_ra = r_p;
            end
            sab_pkg::OP_LINK_Q: begin
                lk_we = 1'b1; lk_wa = r_cur; lk_wd = r_q;
            end
            sab_pkg::OP_CL_INIT: begin
                ln_we = 1'b1; ln_wa = r_cnt + SW'(1); ln_wd = r_plen + LW'(1);
            end
            sab_pkg::OP_CP_RD: begin
                nx_re = 1'b1; nx_ra = f_addr(r_q, r_k);
            end
            sab_pkg::OP_CP_WR: begin
                nx_we = 1'b1; nx_wa = f_addr(r_cl, r_k); nx_wd = nx_rd;
            end
            sab_pkg::OP_RD_LQ: begin
                lk_re = 1'b1; lk_ra = r_q;
            end
            sab_pkg::OP_WR_LCL: begin
                lk_we = 1'b1; lk_wa = r_cl; lk_wd = lk_rd;
            end
            sab_pkg::OP_WR_LCUR: begin
                lk_we = 1'b1; lk_wa = r_cur; lk_wd = r_cl;
            end
            sab_pkg::OP_WR_LQ: begin
                lk_we = 1'b1; lk_wa = r_q; lk_wd = r_cl;
            end
            sab_pkg::OP_SET_CL: begin
                nx_we = 1'b1; nx_wa = f_addr(r_p, r_c); nx_wd = r_cl;
                lk_re = 1'b1; lk_ra = r_p;
            end
            sab_pkg::OP_QUERY: begin
                nx_re = 1'b1; nx_ra = f_addr(SW'(r_item.query_state), KW'(r_item.symbol));
                ln_re = 1'b1; ln_ra = SW'(r_item.query_state);
                lk_re = 1'b1; lk_ra = SW'(r_item.query_state);
            end
            default: begin
                nx_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= SW'(1); r_cnt <= SW'(1); r_llen <= '0;
            r_k <= '0; r_strobe <= 1'b0;
        end else begin
            r_strobe <= (i_cmd.op == sab_pkg::OP_EMIT);
            unique case (i_cmd.op)
                sab_pkg::OP_CLR_INIT: begin
                    r_last <= SW'(1); r_cnt <= SW'(1); r_llen <= '0; r_k <= '0;
                end
                sab_pkg::OP_CLR_ROW, sab_pkg::OP_ZERO_ROW, sab_pkg::OP_CP_WR: begin
                    r_k <= k_last ? '0 : r_k + KW'(1);
                end
                sab_pkg::OP_APP_INIT: begin
                    r_cnt  <= r_cnt + SW'(1);
                    r_cur  <= r_cnt + SW'(1);
                    r_last <= r_cnt + SW'(1);
                    r_llen <= r_llen + LW'(1);
                    r_k    <= '0;
                end
                sab_pkg::OP_CL_INIT: begin
                    r_cnt <= r_cnt + SW'(1);
                    r_cl  <= r_cnt + SW'(1);
                    r_k   <= '0;
                end
                default: begin
                    r_k <= r_k;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_item   <= i_item;
            r_c      <= KW'(i_item.symbol);
            r_cloned <= 1'b0;
            r_ovf    <= 1'b0;
        end
        unique case (i_cmd.op)
            sab_pkg::OP_APP_INIT: r_p <= r_last;
            sab_pkg::OP_STEP_P:  r_p <= (r_p == SW'(1)) ? '0 : lk_rd;
            sab_pkg::OP_TAKE_Q:  r_q <= nx_rd;
            sab_pkg::OP_TAKE_QL: r_qlen <= ln_rd;
            sab_pkg::OP_TAKE_PL: r_plen <= plen_now;
            sab_pkg::OP_CL_INIT: r_cloned <= 1'b1;
            sab_pkg::OP_OVF:     r_ovf <= 1'b1;
            sab_pkg::OP_EMIT: begin
                r_result.new_state    <= 12'(r_last);
                r_result.state_total  <= 12'(r_cnt);
                r_result.cloned       <= r_cloned;
                r_result.overflow     <= r_ovf;
                r_result.state_length <= (is_query && q_in2) ? 11'(ln_rd) : '0;
                r_result.suffix_link  <= (is_query && q_in2) ? 12'(lk_rd) : '0;
                r_result.transition   <= (is_query && q_in && sym_ok) ? 12'(nx_rd) : '0;
            end
            default: begin
                r_q <= r_q;
            end
        endcase
    end

    sab_ram #(.WIDTH(SW), .DEPTH(ND)) u_next (
        .i_clk(i_clk), .i_we(nx_we), .i_waddr(nx_wa), .i_wdata(nx_wd),
        .i_re(nx_re), .i_raddr(nx_ra), .o_rdata(nx_rd)
    );
    sab_ram #(.WIDTH(LW), .DEPTH(NSTATES)) u_len (
        .i_clk(i_clk), .i_we(ln_we), .i_waddr(ln_wa), .i_wdata(ln_wd),
        .i_re(ln_re), .i_raddr(ln_ra), .o_rdata(ln_rd)
    );
    sab_ram #(.WIDTH(SW), .DEPTH(NSTATES)) u_link (
        .i_clk(i_clk), .i_we(lk_we), .i_waddr(lk_wa), .i_wdata(lk_wd),
        .i_re(lk_re), .i_raddr(lk_ra), .o_rdata(lk_rd)
    );

    assign o_sts.mode      = r_item.mode;
    assign o_sts.sym_ok    = sym_ok;
    assign o_sts.room      = (32'(r_llen) < MAX_LEN);
    assign o_sts.k_last    = k_last;
    assign o_sts.next_zero = (nx_rd == '0);
    assign o_sts.next_is_q = (nx_rd == r_q);
    assign o_sts.len_match = ((LW + 1)'(r_qlen) == (LW + 1)'(plen_now) + (LW + 1)'(1));
    assign o_sts.p_zero    = (r_p == SW'(1)) || (lk_rd == '0);
    assign o_result        = r_result;
    assign o_strobe        = r_strobe;
endmodule

>>> hw/rtl/suffix_automaton_builder.sv
// A query reads all three memories at once; a restart clears the root row; an append walks the suffix links.
// A clone adds the row copy and a redirect step for each redirected link.
// An append zeroes the new row and a clone copies the cloned row, both through the single write port
// of the transition memory; each link of a walk passes the read, check, set and step states.
// Result strobe follows the done cycle; the next word may start in the strobe cycle, so words
// issue one at a time and the receiver cannot stall. Reset is synchronous; after it the
// root row is cleared (busy high).
// ----------------------------------------------------------------------------
// Suffix automaton builder
// Online suffix automaton construction with restart, append and query words.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module suffix_automaton_builder #(
    parameter int MAX_LEN  = 1024,
    parameter int ALPHABET = 26
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  sab_pkg::t_in  i_item,
    output logic          o_strobe,
    output sab_pkg::t_out o_result
);
    sab_pkg::t_cmd cmd;
    sab_pkg::t_sts sts;

    sab_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start),
        .i_sts(sts), .o_cmd(cmd), .o_busy(busy)
    );

    sab_dp #(.MAX_LEN(MAX_LEN), .ALPHABET(ALPHABET)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .i_item(i_item),
        .o_sts(sts), .o_result(o_result), .o_strobe(o_strobe)
    );

    `SAB_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    `SAB_ASSERT_IMP(a_strobe_idle, i_clk, i_rst_n, o_strobe, !busy)
    `SAB_ASSERT_NXT(a_strobe_single, i_clk, i_rst_n, o_strobe, !o_strobe)
    `SAB_ASSERT_IMP(a_ovf_noclone, i_clk, i_rst_n, o_strobe && o_result.overflow, !o_result.cloned)
endmodule
